// ----- hw/rtl/tgarle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared widths, register indexes, reset values and the result item type.
// ----------------------------------------------------------------------------
package tgarle_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned PIXEL_W     = 32;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned NBYTES_W    = 3;
   localparam int unsigned TOTAL_W     = 30;
   localparam int unsigned INDEX_W     = 2;
   localparam int unsigned CSR_ADDR_W  = 1;
   localparam int unsigned CSR_DATA_W  = 30;

   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_BYTES  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_TOTAL_PIXELS = 1'b1;

   localparam logic [NBYTES_W-1:0] PIXEL_BYTES_RESET  = 3'd4;
   localparam logic [TOTAL_W-1:0]  TOTAL_PIXELS_RESET = 30'd1;
   localparam logic [PIXEL_W-1:0]  ALPHA_PRESET       = 32'h0000_00ff;

   localparam logic [BYTE_W-1:0] RUN_HEADER_MIN = 8'd128;
   localparam logic [BYTE_W-1:0] RUN_BIAS       = 8'd127;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel_word;
      logic [COUNT_W-1:0] repeat_count;
      logic               image_done;
      logic               overflow;
   } result_type;

endpackage : tgarle_pkg

// ----- hw/rtl/tgarle_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE decoder core
// Packet and pixel state; turns one accepted byte into zero or one result.
// ----------------------------------------------------------------------------
module tgarle_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [tgarle_pkg::BYTE_W-1:0] data_byte,
   input  logic                         frame_start,
   input  logic [tgarle_pkg::NBYTES_W-1:0] pixel_bytes,
   input  logic [tgarle_pkg::TOTAL_W-1:0]  total_pixels,
   output logic                         res_valid,
   output tgarle_pkg::result_type       res_data
);
   import tgarle_pkg::*;

   logic                 in_header_ff,   in_header_in;
   logic                 run_packet_ff,  run_packet_in;
   logic [COUNT_W-1:0]   packet_left_ff, packet_left_in;
   logic [INDEX_W-1:0]   byte_index_ff,  byte_index_in;
   logic [PIXEL_W-1:0]   assembly_ff,    assembly_in;
   logic [TOTAL_W-1:0]   pixels_left_ff, pixels_left_in;
   logic                 stopped_ff,     stopped_in;

   logic [NBYTES_W-1:0]  nb;
   logic [COUNT_W-1:0]   cnt;
   logic [COUNT_W-1:0]   rep;
   logic [INDEX_W-1:0]   lane;
   logic [NBYTES_W-1:0]  index_next;
   logic [PIXEL_W-1:0]   assembled;

   // clamp the pixel size into 1..4
   always_comb begin
      if (pixel_bytes == '0) begin
         nb = NBYTES_W'(1);
      end else if (pixel_bytes > NBYTES_W'(4)) begin
         nb = NBYTES_W'(4);
      end else begin
         nb = pixel_bytes;
      end
   end

   always_comb begin
      // start from the registered view of the state
      in_header_in   = in_header_ff;
      run_packet_in  = run_packet_ff;
      packet_left_in = packet_left_ff;
      byte_index_in  = byte_index_ff;
      assembly_in    = assembly_ff;
      pixels_left_in = pixels_left_ff;
      stopped_in     = stopped_ff;
      res_valid      = 1'b0;
      res_data       = '0;
      cnt            = '0;
      rep            = '0;
      lane           = '0;
      index_next     = '0;
      assembled      = '0;

      if (accept) begin
         if (frame_start) begin
            in_header_in   = 1'b1;
            run_packet_in  = 1'b0;
            packet_left_in = '0;
            byte_index_in  = '0;
            assembly_in    = ALPHA_PRESET;
            pixels_left_in = total_pixels;
            stopped_in     = 1'b0;
         end

         if (!stopped_in && pixels_left_in != '0) begin
            if (in_header_in) begin
               if (data_byte >= RUN_HEADER_MIN) begin
                  cnt = data_byte - RUN_BIAS;
                  run_packet_in = 1'b1;
               end else begin
                  cnt = data_byte + COUNT_W'(1);
                  run_packet_in = 1'b0;
               end
               if ({{(TOTAL_W-COUNT_W){1'b0}}, cnt} > pixels_left_in) begin
                  // packet does not fit: report and drop the rest of the frame
                  stopped_in          = 1'b1;
                  res_valid           = 1'b1;
                  res_data.overflow   = 1'b1;
               end else begin
                  packet_left_in = cnt;
                  in_header_in   = 1'b0;
                  byte_index_in  = '0;
               end
            end else begin
               // byte lane for this byte of the pixel
               if (nb == NBYTES_W'(2)) begin
                  lane = byte_index_in;
               end else begin
                  lane = (byte_index_in < INDEX_W'(3)) ? byte_index_in + INDEX_W'(1)
                                                        : INDEX_W'(0);
               end
               if (nb == NBYTES_W'(1)) begin
                  assembled = {{(PIXEL_W-BYTE_W){1'b0}}, data_byte};
               end else begin
                  assembled = assembly_in;
                  assembled[lane*BYTE_W +: BYTE_W] = data_byte;
               end
               assembly_in = assembled;

               index_next = {1'b0, byte_index_in} + NBYTES_W'(1);
               if (index_next < nb) begin
                  byte_index_in = index_next[INDEX_W-1:0];
               end else begin
                  byte_index_in = '0;
                  if (run_packet_in) begin
                     rep            = packet_left_in;
                     packet_left_in = '0;
                  end else begin
                     rep            = COUNT_W'(1);
                     packet_left_in = packet_left_in - COUNT_W'(1);
                  end
                  if ({{(TOTAL_W-COUNT_W){1'b0}}, rep} <= pixels_left_in) begin
                     pixels_left_in = pixels_left_in - {{(TOTAL_W-COUNT_W){1'b0}}, rep};
                  end else begin
                     pixels_left_in = '0;
                  end
                  if (packet_left_in == '0) begin
                     in_header_in = 1'b1;
                  end
                  res_valid             = 1'b1;
                  res_data.pixel_word   = assembled;
                  res_data.repeat_count = rep;
                  res_data.image_done   = (pixels_left_in == '0);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_header_ff   <= 1'b1;
         run_packet_ff  <= 1'b0;
         packet_left_ff <= '0;
         byte_index_ff  <= '0;
         assembly_ff    <= ALPHA_PRESET;
         pixels_left_ff <= '0;
         stopped_ff     <= 1'b0;
      end else begin
         in_header_ff   <= in_header_in;
         run_packet_ff  <= run_packet_in;
         packet_left_ff <= packet_left_in;
         byte_index_ff  <= byte_index_in;
         assembly_ff    <= assembly_in;
         pixels_left_ff <= pixels_left_in;
         stopped_ff     <= stopped_in;
      end
   end

endmodule : tgarle_core

// ----- hw/rtl/tgarle_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE decoder output buffer
// Result register with a skid stage so the input side runs on while rsp stalls, until the skid stage is occupied.
// ----------------------------------------------------------------------------
module tgarle_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tgarle_pkg::result_type in_data,
   output logic                   full,
   output logic                   out_valid,
   output tgarle_pkg::result_type out_data,
   input  logic                   out_stall
);
   import tgarle_pkg::*;

   logic       out_valid_ff,  out_valid_in;
   result_type out_data_ff,   out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff,  skid_data_in;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || !out_stall) begin
         // output slot frees up: refill from skid first, else from the core
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule : tgarle_out_buf

// ----- hw/rtl/tga_rle_pixel_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes a run-length coded TGA pixel stream, one byte per item, into
// pixels with repeat counts; flags a packet that overruns the image.
//
//   channel | direction | handshake         | payload
//   req     | in        | req_valid/stall   | data_byte, frame_start
//   rsp     | out       | rsp_valid/stall   | pixel_word, repeat_count,
//           |           |                   | image_done, overflow
//   csr     | in        | csr_write_enable  | csr_index, csr_write_data
//
// One byte is taken per cycle while req_stall is low; the packet and pixel
// state updates in the same cycle; a result passes that single state update
// and the output register before it reaches rsp. A skid stage absorbs one
// result when rsp stalls; req_stall rises only while that stage is occupied.
// Reset is synchronous and leaves the decoder ignoring bytes until an item
// with frame_start.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [tgarle_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                               req_frame_start,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [tgarle_pkg::PIXEL_W-1:0]     rsp_pixel_word,
   output logic [tgarle_pkg::COUNT_W-1:0]     rsp_repeat_count,
   output logic                               rsp_image_done,
   output logic                               rsp_overflow,
   input  logic                               csr_write_enable,
   input  logic [tgarle_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [tgarle_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import tgarle_pkg::*;

   logic [NBYTES_W-1:0] pixel_bytes_ff;
   logic [TOTAL_W-1:0]  total_pixels_ff;
   logic                accept;
   logic                res_valid;
   result_type          res_data;
   logic                buf_full;
   result_type          rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_bytes_ff  <= PIXEL_BYTES_RESET;
         total_pixels_ff <= TOTAL_PIXELS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PIXEL_BYTES:  pixel_bytes_ff  <= csr_write_data[NBYTES_W-1:0];
            CSR_TOTAL_PIXELS: total_pixels_ff <= csr_write_data[TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = buf_full;
   assign accept    = req_valid && !req_stall;

   tgarle_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .data_byte    (req_data_byte),
      .frame_start  (req_frame_start),
      .pixel_bytes  (pixel_bytes_ff),
      .total_pixels (total_pixels_ff),
      .res_valid    (res_valid),
      .res_data     (res_data)
   );

   tgarle_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_data   (res_data),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

   assign rsp_pixel_word   = rsp_data.pixel_word;
   assign rsp_repeat_count = rsp_data.repeat_count;
   assign rsp_image_done   = rsp_data.image_done;
   assign rsp_overflow     = rsp_data.overflow;

endmodule : tga_rle_pixel_decoder

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Drives run-length coded byte streams into the decoder with random gaps and
// output stalls. A scoreboard class predicts every pixel and overflow result
// from its own copy of the decoder state and checks the rsp channel in order.
// ----------------------------------------------------------------------------
module testbench;
   import tgarle_pkg::*;

   localparam int CYCLE_LIMIT = 300000;
   localparam int RANDOM_ITEMS = 1450;
   localparam int HOLD_CYCLES = 300;

   class pixel_scoreboard;
      logic [NBYTES_W-1:0] pixel_bytes_reg;
      logic [TOTAL_W-1:0]  total_reg;
      bit                  in_header;
      bit                  run_packet;
      logic [COUNT_W-1:0]  packet_left;
      logic [INDEX_W-1:0]  byte_index;
      logic [PIXEL_W-1:0]  assembly;
      logic [TOTAL_W-1:0]  pixels_left;
      bit                  stopped;
      result_type          expected_q[$];
      int                  errors;

      function new();
         pixel_bytes_reg = PIXEL_BYTES_RESET;
         total_reg = TOTAL_PIXELS_RESET;
         in_header = 1;
         run_packet = 0;
         packet_left = '0;
         byte_index = '0;
         assembly = ALPHA_PRESET;
         pixels_left = '0;
         stopped = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_ADDR_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         if (idx == CSR_PIXEL_BYTES) pixel_bytes_reg = value[NBYTES_W-1:0];
         else if (idx == CSR_TOTAL_PIXELS) total_reg = value[TOTAL_W-1:0];
      endfunction

      function int size_now();
         if (pixel_bytes_reg == 0) return 1;
         if (pixel_bytes_reg > 4) return 4;
         return int'(pixel_bytes_reg);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Returns 1 when the byte was decoded, 0 when the decoder ignored it.
      function bit note_input(logic [BYTE_W-1:0] b, logic fs);
         int unsigned cnt;
         int unsigned rep;
         int nb;
         int lane;
         result_type r;
         if (fs) begin
            in_header = 1;
            run_packet = 0;
            packet_left = '0;
            byte_index = '0;
            assembly = ALPHA_PRESET;
            pixels_left = total_reg;
            stopped = 0;
         end
         if (stopped || pixels_left == 0) return 0;
         nb = size_now();
         if (in_header) begin
            if (b >= RUN_HEADER_MIN) begin
               cnt = 32'(b) - 32'(RUN_BIAS);
               run_packet = 1;
            end else begin
               cnt = 32'(b) + 1;
               run_packet = 0;
            end
            if (cnt > pixels_left) begin
               stopped = 1;
               r.pixel_word = '0;
               r.repeat_count = '0;
               r.image_done = 0;
               r.overflow = 1;
               expected_q.push_back(r);
               return 1;
            end
            packet_left = cnt[COUNT_W-1:0];
            in_header = 0;
            byte_index = '0;
            return 1;
         end
         if (nb == 1) begin
            assembly = {24'h0, b};
         end else begin
            if (nb == 2) lane = int'(byte_index);
            else lane = (byte_index < 3) ? int'(byte_index) + 1 : 0;
            assembly[8*lane +: 8] = b;
         end
         if (int'(byte_index) + 1 < nb) begin
            byte_index = byte_index + INDEX_W'(1);
            return 1;
         end
         byte_index = '0;
         if (run_packet) begin
            rep = 32'(packet_left);
            packet_left = '0;
         end else begin
            rep = 1;
            packet_left = packet_left - COUNT_W'(1);
         end
         pixels_left = (rep <= pixels_left) ? pixels_left - TOTAL_W'(rep) : '0;
         if (packet_left == 0) in_header = 1;
         r.pixel_word = assembly;
         r.repeat_count = rep[COUNT_W-1:0];
         r.image_done = (pixels_left == 0);
         r.overflow = 0;
         expected_q.push_back(r);
         return 1;
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result pixel_word %h repeat_count %0d done %0b ovf %0b",
                     $time, got.pixel_word, got.repeat_count, got.image_done, got.overflow);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.pixel_word !== want.pixel_word) begin
            $display("%0t: pixel_word expected %h actual %h", $time, want.pixel_word,
                     got.pixel_word);
            errors++;
         end
         if (got.repeat_count !== want.repeat_count) begin
            $display("%0t: repeat_count expected %0d actual %0d", $time, want.repeat_count,
                     got.repeat_count);
            errors++;
         end
         if (got.image_done !== want.image_done) begin
            $display("%0t: image_done expected %0b actual %0b", $time, want.image_done,
                     got.image_done);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time, want.overflow,
                     got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [BYTE_W-1:0]     req_data_byte;
   logic                  req_frame_start;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [PIXEL_W-1:0]    rsp_pixel_word;
   logic [COUNT_W-1:0]    rsp_repeat_count;
   logic                  rsp_image_done;
   logic                  rsp_overflow;
   logic                  csr_write_enable;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   pixel_scoreboard sb = new();
   int  cycle_count = 0;
   int  sent_count = 0;
   bit  quiet = 0;
   bit  hold_request = 0;

   tga_rle_pixel_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_word   (rsp_pixel_word),
      .rsp_repeat_count (rsp_repeat_count),
      .rsp_image_done   (rsp_image_done),
      .rsp_overflow     (rsp_overflow),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[tga_rle_pixel_decoder] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result('{rsp_pixel_word, rsp_repeat_count, rsp_image_done, rsp_overflow});
   end

   // Receiver: random stall bursts, or one long hold-off on request.
   initial begin
      rsp_stall <= 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            rsp_stall <= 1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   task automatic send_item(input logic [BYTE_W-1:0] b, input logic fs);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1;
      req_data_byte <= b;
      req_frame_start <= fs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      void'(sb.note_input(b, fs));
      sent_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   // Packets with random content, now and then one that overruns the image; broken frames may end mid-packet.
   task automatic send_frame(input int max_packets, input bit broken);
      int pk;
      int rem;
      int cnt;
      int nb;
      int n;
      int r;
      bit first;
      bit run;
      bit cut;
      first = 1;
      rem = int'(sb.total_reg);
      for (pk = 0; pk < max_packets; pk++) begin
         if (!first) begin
            rem = int'(sb.pixels_left);
            if (sb.stopped || rem == 0) break;
         end
         r = $urandom_range(0, 19);
         if (r == 0) cnt = rem + $urandom_range(1, 3);
         else if (r < 3) cnt = $urandom_range(1, 128);
         else cnt = $urandom_range(1, 8);
         if (r != 0 && cnt > rem) cnt = (rem > 0) ? rem : 1;
         if (cnt > 128) cnt = 128;
         if (cnt < 1) cnt = 1;
         run = 1'($urandom_range(0, 1));
         send_item(run ? BYTE_W'(cnt + 127) : BYTE_W'(cnt - 1), first);
         first = 0;
         if (sb.stopped) break;
         nb = sb.size_now();
         n = run ? nb : cnt * nb;
         cut = broken && ($urandom_range(0, 2) == 0);
         if (cut) n = $urandom_range(0, n - 1);
         repeat (n) send_item(BYTE_W'($urandom), 0);
         if (cut) break;
      end
   endtask

   initial begin
      int phase;
      int quota_end;
      int frames;
      int r;
      logic [NBYTES_W-1:0] pb;
      logic [TOTAL_W-1:0]  total;

      reset <= 1;
      req_valid <= 0;
      req_data_byte <= '0;
      req_frame_start <= 0;
      csr_write_enable <= 0;
      csr_index <= CSR_PIXEL_BYTES;
      csr_write_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Reset settings: four bytes per pixel, one pixel per image.
      send_item(8'h3c, 0);              // ignored before any frame start
      send_item(8'hc3, 0);
      send_item(8'h80, 1);
      send_item(8'h00, 0);
      send_item(8'hff, 0);
      send_item(8'h5a, 0);
      send_item(8'ha5, 0);
      send_item(8'h12, 0);              // ignored after image complete
      send_item(8'h81, 1);              // run of two overflows
      send_item(8'h00, 0);              // ignored after overflow
      wait_idle();

      write_csr(CSR_PIXEL_BYTES, 3);
      write_csr(CSR_TOTAL_PIXELS, 130);
      send_item(8'hff, 1);              // longest run
      repeat (3) send_item(BYTE_W'($urandom), 0);
      send_item(8'h00, 0);
      repeat (3) send_item(BYTE_W'($urandom), 0);
      send_item(8'h01, 0);              // literal overflow
      wait_idle();

      // Change the pixel size in the middle of a pixel.
      write_csr(CSR_PIXEL_BYTES, 2);
      write_csr(CSR_TOTAL_PIXELS, 4);
      send_item(8'h01, 1);
      send_item(8'h11, 0);
      wait_idle();
      write_csr(CSR_PIXEL_BYTES, 4);
      send_item(8'h22, 0);
      send_item(8'h33, 0);
      send_item(8'h44, 0);
      wait_idle();
      write_csr(CSR_PIXEL_BYTES, 1);
      send_item(8'h55, 0);
      send_item(8'h80, 0);
      send_item(8'hee, 0);
      send_item(8'h7f, 0);              // literal of 128 overflows
      wait_idle();

      // Fill the block while the receiver holds off, then drain.
      write_csr(CSR_PIXEL_BYTES, 1);
      write_csr(CSR_TOTAL_PIXELS, 200);
      hold_request = 1;
      send_frame(20, 0);
      wait_idle();

      quota_end = RANDOM_ITEMS;
      phase = 0;
      while (sent_count < quota_end) begin
         case (phase)
            0: begin pb = 0; total = 30'h3fffffff; end
            1: begin pb = 7; total = 0; end
            2: begin pb = 5; total = 1; end
            3: begin pb = 6; total = 30'd1073676289; end
            default: begin
               r = $urandom_range(0, 9);
               pb = (r < 8) ? NBYTES_W'(1 + r % 4) : NBYTES_W'($urandom_range(0, 7));
               r = $urandom_range(0, 15);
               if (r == 0) total = 0;
               else if (r == 1) total = 30'h3fffffff;
               else if (r == 2) total = TOTAL_W'($urandom);
               else if (r == 3) total = 1;
               else total = TOTAL_W'($urandom_range(1, 60));
            end
         endcase
         write_csr(CSR_PIXEL_BYTES, CSR_DATA_W'(pb));
         if (phase < 4 || $urandom_range(0, 3) != 0) write_csr(CSR_TOTAL_PIXELS, total);
         if (phase == 9) hold_request = 1;
         if (sent_count > quota_end - 200) quiet = 1;
         frames = $urandom_range(1, 4);
         repeat (frames) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
               send_frame($urandom_range(1, 12), 0);
            end else if (r < 8) begin
               send_frame($urandom_range(1, 12), 1);
            end else begin
               repeat ($urandom_range(5, 20))
                  send_item(BYTE_W'($urandom), $urandom_range(0, 7) == 0);
            end
            if ($urandom_range(0, 3) == 0) send_item(BYTE_W'($urandom), 0);
         end
         wait_idle();
         phase++;
      end

      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sb.pending());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("[tga_rle_pixel_decoder] OK");
      end else begin
         $display("[tga_rle_pixel_decoder] ERROR");
      end
      $finish;
   end

endmodule
